### src/dssm_pkg.sv
// Shared types and constants for the two-stack shared memory block.
package dssm_pkg;

  localparam int unsigned DEPTH  = 128;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_PUSH_LOW  = 2'd0,
    REQ_PUSH_HIGH = 2'd1,
    REQ_POP_LOW   = 2'd2,
    REQ_POP_HIGH  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_OVERFLOW  = 2'd1,
    STS_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [1:0]               status;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;     // capture the request on an input transfer
    logic exec;      // commit the request to counts and memory
    logic load_mem;  // move registered read data into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic pop_ok;    // latched request is a pop on a non-empty stack
    logic slot_free; // output register can take a result this cycle
  } sts_t;

endpackage

### src/dssm_ctrl.sv
// Request sequencer for the two-stack shared memory block.
module dssm_ctrl import dssm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_READ = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // A good pop only needs the memory; everything else needs the output slot.
        if (sts_i.pop_ok) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_READ;
        end else if (sts_i.slot_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts_i.slot_free) begin
          cmd_o.load_mem = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/dssm_datapath.sv
// Stack counters, shared word memory and output register.
module dssm_datapath import dssm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t in_req_i,
  input  logic out_stall_i,
  output logic out_valid_o,
  output rsp_t out_rsp_o,
  input  cmd_t cmd_i,
  output sts_t sts_o
);

  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   DepthSum = (CNT_W + 1)'(DEPTH);

  req_t              req_q;
  logic [CNT_W-1:0]  low_q, low_d;
  logic [CNT_W-1:0]  high_q, high_d;
  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  rsp_t              rsp_q;
  logic              out_valid_q;

  logic              is_push, is_low, full, sel_empty, push_ok, pop_ok;
  logic [CNT_W:0]    used;
  logic [CNT_W-1:0]  wr_ptr, rd_ptr;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  rsp_t              exec_rsp;
  logic              load_rsp;

  assign is_push   = (req_q.req_type == REQ_PUSH_LOW) || (req_q.req_type == REQ_PUSH_HIGH);
  assign is_low    = (req_q.req_type == REQ_PUSH_LOW) || (req_q.req_type == REQ_POP_LOW);
  assign used      = {1'b0, low_q} + {1'b0, high_q};
  assign full      = (used == DepthSum);
  assign sel_empty = is_low ? (low_q == '0) : (high_q == '0);
  assign push_ok   = is_push && !full;
  assign pop_ok    = !is_push && !sel_empty;

  // Low stack fills up from word 0, high stack down from the last word.
  assign wr_ptr  = is_low ? low_q : (DepthCnt - CNT_W'(1) - high_q);
  assign rd_ptr  = is_low ? (low_q - CNT_W'(1)) : (DepthCnt - high_q);
  assign wr_addr = wr_ptr[ADDR_W-1:0];
  assign rd_addr = rd_ptr[ADDR_W-1:0];

  assign sts_o.pop_ok    = pop_ok;
  assign sts_o.slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if (cmd_i.exec) begin
      if (push_ok) begin
        if (is_low) low_d = low_q + CNT_W'(1);
        else        high_d = high_q + CNT_W'(1);
      end else if (pop_ok) begin
        if (is_low) low_d = low_q - CNT_W'(1);
        else        high_d = high_q - CNT_W'(1);
      end
    end
  end

  always_comb begin
    if (is_push) begin
      exec_rsp.pop_value = '0;
      exec_rsp.status    = full ? STS_OVERFLOW : STS_OK;
    end else begin
      exec_rsp.pop_value = '1;
      exec_rsp.status    = STS_UNDERFLOW;
    end
  end

  assign load_rsp = (cmd_i.exec && !pop_ok) || cmd_i.load_mem;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) req_q <= in_req_i;
    if (cmd_i.exec && push_ok) mem_q[wr_addr] <= req_q.push_value;
    if (cmd_i.exec && pop_ok) rdata_q <= mem_q[rd_addr];
    if (cmd_i.load_mem) begin
      rsp_q.pop_value <= rdata_q;
      rsp_q.status    <= STS_OK;
    end else if (cmd_i.exec && !pop_ok) begin
      rsp_q <= exec_rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
      if (load_rsp) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_no_overcommit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= DepthSum)
    else $error("stack counts exceed memory depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_rsp && out_valid_q |-> !out_stall_i)
    else $error("pending result overwritten");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && push_ok |=> used == $past(used) + (CNT_W + 1)'(1))
    else $error("accepted push did not grow the stacks");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && pop_ok |=> used == $past(used) - (CNT_W + 1)'(1))
    else $error("good pop did not shrink the stacks");

endmodule

### src/dual_stack_shared_memory.sv
// Top level of the two-stack shared memory block.
//
// Two LIFO stacks share one memory of DEPTH (128) 32-bit words: the low stack
// grows up from word 0, the high stack grows down from the last word. Each
// request transfer (push or pop on either stack) gives exactly one result
// transfer. A push into a full memory answers overflow with value 0 and changes
// nothing; a pop on an empty stack answers underflow with value -1; a push that
// fits answers ok with value 0; a good pop answers ok with the popped word.
// One request is in work at a time. A push or a failed request passes through
// the transfer cycle, then execute, where its result is written into the
// output register. A good pop passes through transfer, execute and read, since
// the memory read is registered in execute and only moved into the output
// register in read. A result that still waits on out_stall_i holds the next
// request in execute or read until the output register frees up. The input is
// stalled from the cycle after a transfer until the result is written into the
// output register, so the next request can enter while the previous result
// still waits on out_stall_i. There is no clearing pass after reset: only words
// written by pushes are ever read.
module dual_stack_shared_memory import dssm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence each request: capture, commit, and for pops the read-data handoff.
  dssm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the stack counts, the shared memory and the output register.
  dssm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
